// File: hw/rtl/hcbt_pkg.sv
package hcbt_pkg;

	// width of the chunk size accumulator
	localparam int SIZE_BITS = 32;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	// trailer end marker, CR LF CR LF
	localparam logic [31:0] END_MARK = 32'h0D0A0D0A;

	// framing bytes after each chunk payload
	localparam logic [SIZE_BITS:0] FRAME_BYTES = (SIZE_BITS + 1)'(2);

	typedef enum logic [1:0] {
		PH_LINE   = 2'd0,
		PH_DATA   = 2'd1,
		PH_TRAIL  = 2'd2,
		PH_DIGITS = 2'd3
	} phase_t;

	typedef struct packed {
		logic is_hex;
		logic [3:0] value;
	} hex_t;

	// hex digit decode
	function automatic hex_t hex_decode(input logic [7:0] b);
		hex_t h;
		h.is_hex = 1'b0;
		h.value  = 4'd0;
		if (b inside {[8'h30:8'h39]}) begin
			h.is_hex = 1'b1;
			h.value  = 4'(b - 8'h30);
		end else if (b inside {[8'h61:8'h66]}) begin
			h.is_hex = 1'b1;
			h.value  = 4'(b - 8'h61 + 8'd10);
		end else if (b inside {[8'h41:8'h46]}) begin
			h.is_hex = 1'b1;
			h.value  = 4'(b - 8'h41 + 8'd10);
		end
		return h;
	endfunction

	// blanks skipped before the first digit
	function automatic logic is_blank(input logic [7:0] b);
		return b inside {8'h20, 8'h09, 8'h0D, 8'h0A, 8'h0B, 8'h0C};
	endfunction

endpackage

// File: hw/rtl/http_chunked_body_tracker.sv
// http chunked body tracker
//
// in channel (in_valid / in_ready / data_byte) takes the message body one byte
// per request, starting right after the header block. out channel (out_valid /
// out_ready) returns one result per byte: is_payload marks chunk data,
// body_done marks the last byte of the trailer, size_overflow marks the end of
// a size line whose hex count saturated at all ones.
//
// an accepted byte passes through the input register, then the framing logic into
// the result register. throughput is one byte per cycle while out_ready stays
// high, as the framing state updates once per accepted byte.
// the input register takes a new byte when it is empty or when the result
// register is being drained or is empty.
//
// reset clears both valid flags and returns the framing state to the start of
// a size line. when out_ready is low the result holds, the input register fills
// and in_ready drops, so no byte is lost. after body_done the tracker starts
// over on the next byte as a fresh chunked body.
module http_chunked_body_tracker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       is_payload,
	output logic       body_done,
	output logic       size_overflow
);
	import hcbt_pkg::*;

	logic valid_s1;
	logic [7:0] byte_s1;
	logic valid_s2;
	logic payload_s2, done_s2, ovf_s2;
	logic adv_s1;

	phase_t phase_q, phase_d;
	logic [SIZE_BITS-1:0] accum_q, accum_d;
	logic ended_q, ended_d;
	logic [SIZE_BITS:0] skip_q, skip_d;
	logic [23:0] recent_q, recent_d;
	logic ovf_seen_q, ovf_seen_d;
	logic payload_d, done_d, ovf_d;

	hex_t hx;
	logic line_end;
	logic [SIZE_BITS:0] skip_dec;

	// stage 1 moves on when the result register is free or being taken
	assign adv_s1   = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
		end
	end

	// framing state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_LINE;
			accum_q    <= '0;
			ended_q    <= 1'b0;
			skip_q     <= '0;
			recent_q   <= '0;
			ovf_seen_q <= 1'b0;
		end else if (valid_s1 && adv_s1) begin
			phase_q    <= phase_d;
			accum_q    <= accum_d;
			ended_q    <= ended_d;
			skip_q     <= skip_d;
			recent_q   <= recent_d;
			ovf_seen_q <= ovf_seen_d;
		end
	end

	assign hx       = hex_decode(byte_s1);
	assign line_end = (byte_s1 == CH_LF) && (recent_q[7:0] == CH_CR);
	assign skip_dec = skip_q - (SIZE_BITS + 1)'(1);

	// next framing state and per-byte flags
	always_comb begin
		phase_d    = phase_q;
		accum_d    = accum_q;
		ended_d    = ended_q;
		skip_d     = skip_q;
		ovf_seen_d = ovf_seen_q;
		recent_d   = {recent_q[15:0], byte_s1};
		payload_d  = 1'b0;
		done_d     = 1'b0;
		ovf_d      = 1'b0;
		case (phase_q)
			PH_DATA: begin
				payload_d = (skip_q > FRAME_BYTES);
				if (skip_q != '0) begin
					skip_d = skip_dec;
				end
				if (skip_d == '0) begin
					phase_d = PH_LINE;
				end
			end
			PH_TRAIL: begin
				if ({recent_q, byte_s1} == END_MARK) begin
					done_d     = 1'b1;
					phase_d    = PH_LINE;
					accum_d    = '0;
					ended_d    = 1'b0;
					skip_d     = '0;
					recent_d   = '0;
					ovf_seen_d = 1'b0;
				end
			end
			PH_LINE, PH_DIGITS: begin
				// accumulate hex digits until the size field ends
				if (!ended_q) begin
					if (hx.is_hex) begin
						if (accum_q[SIZE_BITS-1 -: 4] != 4'd0) begin
							accum_d    = '1;
							ovf_seen_d = 1'b1;
						end else begin
							accum_d = {accum_q[SIZE_BITS-5:0], hx.value};
						end
						phase_d = PH_DIGITS;
					end else if (!(phase_q == PH_LINE && is_blank(byte_s1))) begin
						ended_d = 1'b1;
					end
				end
				// size line ends on CR LF
				if (line_end) begin
					ovf_d = ovf_seen_d;
					if (accum_d != '0) begin
						skip_d  = {1'b0, accum_d} + FRAME_BYTES;
						phase_d = PH_DATA;
					end else begin
						phase_d = PH_TRAIL;
					end
					accum_d    = '0;
					ended_d    = 1'b0;
					ovf_seen_d = 1'b0;
				end
			end
			default: begin
				phase_d = PH_LINE;
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			payload_s2 <= payload_d;
			done_s2    <= done_d;
			ovf_s2     <= ovf_d;
		end
	end

	assign out_valid     = valid_s2;
	assign is_payload    = payload_s2;
	assign body_done     = done_s2;
	assign size_overflow = ovf_s2;

endmodule

// File: hw/rtl/hcbt_checker.sv
module hcbt_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic is_payload,
	input logic body_done,
	input logic size_overflow
);

	// a stalled result holds its flags
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(is_payload)
			&& $stable(body_done) && $stable(size_overflow))
		else $error("stalled result changed");

	// chunk data is never a framing end mark
	a_payload_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(is_payload && (body_done || size_overflow)))
		else $error("payload byte flagged as framing");

	// body end comes from the trailer, not from a size line
	a_done_ovf_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(body_done && size_overflow))
		else $error("done and overflow on one byte");

	// a new result needs an accepted request ahead of it, through the input register
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without request");

endmodule

bind http_chunked_body_tracker hcbt_checker u_hcbt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.is_payload   (is_payload),
	.body_done    (body_done),
	.size_overflow(size_overflow)
);
